// ===== rtl/core/tts_pkg.sv =====
// Shared types and constants for the timed task slot table.
// Used by tts_slot_mem, tts_fire_unit and timed_task_slot_table_top.
// No dependencies.
package tts_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    // Stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 24;

    // Result kinds
    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;
    localparam logic [1:0] KIND_IDLE     = 2'd3;

    // Input opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // One stored timer slot
    typedef struct packed {
        logic        periodic;
        logic [15:0] repeats_left;
        logic [31:0] interval;
        logic [31:0] last_active;
        logic [15:0] param;
    } slot_word_t;

    // Outcome of checking one slot against the current time
    typedef struct packed {
        logic       fire;
        logic       freed;
        slot_word_t upd;
    } fire_res_t;

    // One result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic [15:0] param;
        logic        freed;
        logic [3:0]  free_slots;
        logic        last;
    } res_t;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_ADD_SCAN  = 6'b000010,
        ST_ADD_EMIT  = 6'b000100,
        ST_TICK_READ = 6'b001000,
        ST_TICK_EVAL = 6'b010000,
        ST_TICK_DONE = 6'b100000
    } state_t;

endpackage

// ===== rtl/core/tts_slot_mem.sv =====
// Slot storage: one write port, one registered read port.
// Depends on tts_pkg for the slot word type.
module tts_slot_mem #(
    parameter int SLOT_COUNT = tts_pkg::SLOT_COUNT_DEF
) (
    input  logic                                           aclk,
    input  logic                                           wr_en,
    input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] wr_addr,
    input  tts_pkg::slot_word_t                            wr_data,
    input  logic                                           rd_en,
    input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] rd_addr,
    output tts_pkg::slot_word_t                            rd_data
);

    tts_pkg::slot_word_t mem [SLOT_COUNT];
    tts_pkg::slot_word_t rd_data_reg;

    // Write one slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read word
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tts_fire_unit.sv =====
// Shared elapsed-time subtract and compare, plus the slot update on a firing.
// Depends on tts_pkg for the slot word and result types.
module tts_fire_unit (
    input  tts_pkg::slot_word_t slot_word,
    input  logic [31:0]         now_ms,
    output tts_pkg::fire_res_t  res
);

    logic [31:0] elapsed;

    // Wrap-around elapsed time since last activation
    assign elapsed = now_ms - slot_word.last_active;

    always_comb begin
        res.fire  = (elapsed >= slot_word.interval);
        res.freed = !slot_word.periodic || (slot_word.repeats_left == 16'd1);
        res.upd   = slot_word;
        // Rearm: count down a finite repeat count, restart the interval
        if (slot_word.repeats_left != 16'd0) begin
            res.upd.repeats_left = slot_word.repeats_left - 16'd1;
        end
        res.upd.last_active = now_ms;
    end

endmodule

// ===== rtl/core/timed_task_slot_table_top.sv =====
// Top level of the timed task slot table: sequencer, busy bits, result registers.
// Depends on tts_pkg, tts_slot_mem and tts_fire_unit.
//
// Input channel (s_): one beat is an add (s_tuser = 0) or a tick (s_tuser = 1).
// An add places a task into the lowest free slot and returns one beat, add
// accepted or table full. A tick walks the slots in ascending order and returns
// one beat per task that fires, or a single nothing-fired beat; m_tlast marks
// the final beat of each input.
// Flow: s_tready is high only while the sequencer is idle. An add searches the
// busy bits one slot per cycle for the lowest free slot, then emits its beat.
// A tick skips free slots and reads each busy one through the registered read
// port of the slot memory, feeding the shared elapsed-time compare; a new input
// is taken only once the current one has handed its final beat to the output.
// Each firing beat is held in a pending register until the next firing or the
// end of the scan settles its tlast flag.
// Reset empties every slot at once through the busy bits; no clearing pass.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits at the next beat to be delivered; nothing is dropped.
module timed_task_slot_table_top #(
    parameter int SLOT_COUNT = tts_pkg::SLOT_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: task_param[15:0], interval_ms[47:16], repeat_count[63:48],
    //        repeat_enabled[64], start_offset[96:65], now_ms[128:97], zero pad
    input  logic [tts_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: opcode
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: slot[2:0], fired_param[18:3], slot_freed[19], free_slots[23:20]
    output logic [tts_pkg::OUT_DATA_W-1:0] m_tdata,
    // tuser: kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    localparam int IDX_W = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    tts_pkg::state_t     state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SLOT_COUNT-1:0] busy_reg, busy_next;
    logic [CNT_W-1:0]    free_cnt_reg, free_cnt_next;
    logic                op_reg, op_next;
    logic                full_reg, full_next;
    tts_pkg::slot_word_t item_reg, item_next;
    logic [31:0]         now_reg, now_next;
    logic                pend_valid_reg, pend_valid_next;
    tts_pkg::res_t       pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    tts_pkg::res_t       out_reg, out_next;

    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    tts_pkg::slot_word_t mem_wr_data;
    logic                mem_rd_en;
    tts_pkg::slot_word_t mem_rd_data;
    tts_pkg::fire_res_t  fire_res;

    logic                out_free;
    logic [31:0]         idx_ext;
    logic [31:0]         cnt_dec_ext;
    logic [31:0]         cnt_inc_ext;
    logic [31:0]         cnt_ext;

    tts_slot_mem #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    tts_fire_unit u_fire (
        .slot_word (mem_rd_data),
        .now_ms    (now_reg),
        .res       (fire_res)
    );

    // Widen index and counts to 32 bits for slicing into the result fields
    assign idx_ext     = 32'(idx_reg);
    assign cnt_ext     = 32'(free_cnt_reg);
    assign cnt_dec_ext = 32'(free_cnt_reg - 1'b1);
    assign cnt_inc_ext = 32'(free_cnt_reg + 1'b1);

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == tts_pkg::ST_IDLE);
    assign mem_rd_en = (state_reg == tts_pkg::ST_TICK_READ) && busy_reg[idx_reg];

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        busy_next       = busy_reg;
        free_cnt_next   = free_cnt_reg;
        op_next         = op_reg;
        full_next       = full_reg;
        item_next       = item_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = item_reg;

        unique case (state_reg)
            tts_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next                = s_tuser;
                    full_next              = 1'b0;
                    idx_next               = '0;
                    item_next.param        = s_tdata[15:0];
                    item_next.interval     = s_tdata[47:16];
                    item_next.repeats_left = s_tdata[63:48];
                    item_next.periodic     = s_tdata[64];
                    item_next.last_active  = s_tdata[96:65];
                    now_next               = s_tdata[128:97];
                    state_next = (s_tuser == tts_pkg::OP_TICK) ? tts_pkg::ST_TICK_READ
                                                                : tts_pkg::ST_ADD_SCAN;
                end
            end
            tts_pkg::ST_ADD_SCAN: begin
                // Walk the busy bits for the lowest free slot
                if (!busy_reg[idx_reg]) begin
                    state_next = tts_pkg::ST_ADD_EMIT;
                end else if (idx_reg == IDX_LAST) begin
                    full_next  = 1'b1;
                    state_next = tts_pkg::ST_ADD_EMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tts_pkg::ST_ADD_EMIT: begin
                if (out_free) begin
                    out_valid_next       = 1'b1;
                    out_next.param       = '0;
                    out_next.freed       = 1'b0;
                    out_next.last        = 1'b1;
                    if (full_reg) begin
                        out_next.kind       = tts_pkg::KIND_ADD_FULL;
                        out_next.slot       = '0;
                        out_next.free_slots = cnt_ext[3:0];
                    end else begin
                        mem_wr_en           = 1'b1;
                        busy_next[idx_reg]  = 1'b1;
                        free_cnt_next       = free_cnt_reg - 1'b1;
                        out_next.kind       = tts_pkg::KIND_ADD_OK;
                        out_next.slot       = idx_ext[2:0];
                        out_next.free_slots = cnt_dec_ext[3:0];
                    end
                    state_next = tts_pkg::ST_IDLE;
                end
            end
            tts_pkg::ST_TICK_READ: begin
                // Skip free slots, read busy ones
                if (busy_reg[idx_reg]) begin
                    state_next = tts_pkg::ST_TICK_EVAL;
                end else if (idx_reg == IDX_LAST) begin
                    state_next = tts_pkg::ST_TICK_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tts_pkg::ST_TICK_EVAL: begin
                if (!fire_res.fire || !pend_valid_reg || out_free) begin
                    if (fire_res.fire) begin
                        // Release the previous firing, not the final one
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_next.last  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next.kind  = tts_pkg::KIND_FIRED;
                        pend_next.slot  = idx_ext[2:0];
                        pend_next.param = mem_rd_data.param;
                        pend_next.freed = fire_res.freed;
                        pend_next.last  = 1'b1;
                        if (fire_res.freed) begin
                            busy_next[idx_reg]   = 1'b0;
                            free_cnt_next        = free_cnt_reg + 1'b1;
                            pend_next.free_slots = cnt_inc_ext[3:0];
                        end else begin
                            mem_wr_en            = 1'b1;
                            mem_wr_data          = fire_res.upd;
                            pend_next.free_slots = cnt_ext[3:0];
                        end
                    end
                    if (idx_reg == IDX_LAST) begin
                        state_next = tts_pkg::ST_TICK_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = tts_pkg::ST_TICK_READ;
                    end
                end
            end
            tts_pkg::ST_TICK_DONE: begin
                // Deliver the final beat of the tick
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end else begin
                        out_next.kind       = tts_pkg::KIND_IDLE;
                        out_next.slot       = '0;
                        out_next.param      = '0;
                        out_next.freed      = 1'b0;
                        out_next.free_slots = cnt_ext[3:0];
                        out_next.last       = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = tts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tts_pkg::ST_IDLE;
            idx_reg        <= '0;
            busy_reg       <= '0;
            free_cnt_reg   <= CNT_W'(SLOT_COUNT);
            full_reg       <= 1'b0;
            op_reg         <= tts_pkg::OP_ADD;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            busy_reg       <= busy_next;
            free_cnt_reg   <= free_cnt_next;
            full_reg       <= full_next;
            op_reg         <= op_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        now_reg  <= now_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.free_slots, out_reg.freed, out_reg.param, out_reg.slot};

    // Free count tracks the busy bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(free_cnt_reg) + 32'($countones(busy_reg)) == 32'(SLOT_COUNT))
        else $error("free slot count out of step with busy bits");

    // A pending firing never outlives its tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("pending beat left over at idle");

    // Nothing-fired and add beats are always the final beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != tts_pkg::KIND_FIRED)) |-> m_tlast)
        else $error("non-firing beat without tlast");

    // A tick item only ever drives the tick path
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == tts_pkg::ST_TICK_EVAL) || (state_reg == tts_pkg::ST_TICK_READ))
        |-> (op_reg == tts_pkg::OP_TICK))
        else $error("tick scan running for an add item");

endmodule
